// ===== hdl/fcbc_pkg.sv =====
package fcbc_pkg;

	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [15:0] INC_STEP_RST  = 16'd10;
	localparam logic [15:0] DEC_STEP_RST  = 16'd5;
	localparam logic [15:0] INIT_CNT_RST  = 16'd50;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PERIOD_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INC_STEP = 2'd0,
		REG_DEC_STEP = 2'd1,
		REG_INIT_CNT = 2'd2
	} cfg_reg_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		POS_U     = 3'd0,
		POS_N     = 3'd1,
		POS_E     = 3'd2,
		POS_R     = 3'd3,
		POS_LEN   = 3'd4,
		POS_COLON = 3'd5,
		POS_CMD   = 3'd6,
		POS_CKS   = 3'd7
	} parse_pos_t;

	typedef struct packed {
		logic       frame_ok;
		logic       run_plus;
		logic       run_minus;
		parse_pos_t pos;
	} parse_stat_t;

endpackage

// ===== hdl/fcbc_in_if.sv =====
interface fcbc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== hdl/fcbc_out_if.sv =====
interface fcbc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         blink_led;
	logic                         ack_led;
	logic                         frame_accepted;
	logic [fcbc_pkg::PERIOD_W-1:0] period_now;

	modport source (output valid, output blink_led, output ack_led,
		output frame_accepted, output period_now, input ready);
	modport sink (input valid, input blink_led, input ack_led,
		input frame_accepted, input period_now, output ready);
endinterface

// ===== hdl/fcbc_cfg_if.sv =====
interface fcbc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fcbc_pkg::CFG_IDX_W-1:0]  index;
	logic [fcbc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fcbc_frame_parser.sv =====
module fcbc_frame_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output fcbc_pkg::parse_stat_t stat
);

	fcbc_pkg::parse_pos_t pos_q, pos_d;
	logic [7:0] cks_q, cks_d;
	logic [7:0] cmd_q, cmd_d;

	// next state
	always_comb begin
		pos_d = pos_q;
		cks_d = cks_q;
		cmd_d = cmd_q;
		unique case (pos_q)
			fcbc_pkg::POS_CMD: begin
				cmd_d = rx_byte;
				cks_d = cks_q ^ rx_byte;
				pos_d = fcbc_pkg::POS_CKS;
			end
			fcbc_pkg::POS_CKS: begin
				pos_d = fcbc_pkg::POS_U;
			end
			default: begin
				if ((pos_q == fcbc_pkg::POS_N && rx_byte == fcbc_pkg::CH_N) ||
						(pos_q == fcbc_pkg::POS_E && rx_byte == fcbc_pkg::CH_E) ||
						(pos_q == fcbc_pkg::POS_R && rx_byte == fcbc_pkg::CH_R) ||
						(pos_q == fcbc_pkg::POS_LEN && rx_byte != 8'd0) ||
						(pos_q == fcbc_pkg::POS_COLON && rx_byte == fcbc_pkg::CH_COLON)) begin
					cks_d = cks_q ^ rx_byte;
					pos_d = fcbc_pkg::parse_pos_t'(pos_q + 3'd1);
				end else if (rx_byte == fcbc_pkg::CH_U) begin
					// restart: this byte opens a new frame
					cks_d = fcbc_pkg::CH_U;
					pos_d = fcbc_pkg::POS_N;
				end else begin
					pos_d = fcbc_pkg::POS_U;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		stat.pos = pos_q;
		stat.frame_ok = (pos_q == fcbc_pkg::POS_CKS) && (rx_byte == cks_q);
		stat.run_plus = stat.frame_ok && (cmd_q == fcbc_pkg::CH_PLUS);
		stat.run_minus = stat.frame_ok && (cmd_q == fcbc_pkg::CH_MINUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= fcbc_pkg::POS_U;
			cks_q <= 8'd0;
			cmd_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_d;
			cks_q <= cks_d;
			cmd_q <= cmd_d;
		end
	end

endmodule

// ===== hdl/frame_command_blink_control_top.sv =====
// frame command blink control
// item channel: operation (0 received byte, 1 timer tick) and rx_byte.
// received bytes run a frame parser (header, nonzero length, ':', command,
// xor checksum); a good '+' frame adds increment_step to the period and
// toggles ack_led, a good '-' frame subtracts decrement_step and reloads
// the countdown. ticks count the countdown down; at zero it reloads from
// the period and blink_led toggles.
// result channel: one result per item, with blink_led, ack_led,
// frame_accepted and period_now after that item.
// cfg channel: index 0 increment_step, 1 decrement_step, 2 initial_countdown
// (also loads the countdown); other indexes are ignored. always ready.
// the request loads the input register at the handshake; the result register
// loads from it once the output is free. throughput: one item per cycle while
// the receiver does not stall, set by the combinational state update.
// reset: parser waits for a header start, period and leds clear, countdown
// 50, steps 10 and 5.
// when the receiver stalls, one item waits in the input register and the
// item channel drops ready until the result is taken.
module frame_command_blink_control_top (
	input logic       clk,
	input logic       arst_n,
	fcbc_in_if.sink   item,
	fcbc_out_if.source result,
	fcbc_cfg_if.sink  cfg
);

	localparam int PW = fcbc_pkg::PERIOD_W;

	logic          valid_s1;
	logic          op_s1;
	logic [7:0]    byte_s1;
	logic          advance;

	logic [PW-1:0] inc_q, dec_q;
	logic [PW-1:0] period_q, period_d;
	logic [PW-1:0] count_q, count_d;
	logic          blink_q, blink_d;
	logic          ack_q, ack_d;
	logic          out_valid_q;
	logic          accepted_q;
	logic          is_byte;
	logic          init_wr;
	logic [PW-1:0] count_mid;

	fcbc_pkg::parse_stat_t stat;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign is_byte = (op_s1 == fcbc_pkg::OP_BYTE);
	assign init_wr = cfg.valid && (cfg.index == fcbc_pkg::REG_INIT_CNT);

	fcbc_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance && is_byte),
		.rx_byte (byte_s1),
		.stat    (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1 <= item.operation;
			byte_s1 <= item.rx_byte;
		end
	end

	always_comb begin
		period_d = period_q;
		ack_d = ack_q;
		count_mid = count_q;
		if (!is_byte) begin
			if (count_q != '0) begin
				count_mid = count_q - PW'(1);
			end
		end else if (stat.run_plus) begin
			period_d = period_q + inc_q;
			ack_d = !ack_q;
		end else if (stat.run_minus) begin
			period_d = period_q - dec_q;
			count_mid = period_d;
		end
		count_d = count_mid;
		blink_d = blink_q;
		if (count_mid == '0) begin
			count_d = period_d;
			blink_d = !blink_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= fcbc_pkg::INC_STEP_RST;
			dec_q <= fcbc_pkg::DEC_STEP_RST;
			period_q <= '0;
			count_q <= fcbc_pkg::INIT_CNT_RST;
			blink_q <= 1'b0;
			ack_q <= 1'b0;
			out_valid_q <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			if (advance) begin
				period_q <= period_d;
				if (!init_wr) begin
					count_q <= count_d;
				end
				blink_q <= blink_d;
				ack_q <= ack_d;
				accepted_q <= is_byte && stat.frame_ok;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					fcbc_pkg::REG_INC_STEP: inc_q <= cfg.data;
					fcbc_pkg::REG_DEC_STEP: dec_q <= cfg.data;
					fcbc_pkg::REG_INIT_CNT: count_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.blink_led = blink_q;
	assign result.ack_led = ack_q;
	assign result.frame_accepted = accepted_q;
	assign result.period_now = period_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("item channel stalled without a waiting result");

	a_frame_returns_to_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_byte && stat.frame_ok) |=> (stat.pos == fcbc_pkg::POS_U))
		else $error("parser did not restart after a good frame");

	a_ack_only_on_plus: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !(is_byte && stat.run_plus)) |=> $stable(ack_q))
		else $error("ack led changed without a plus frame");

	a_accept_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !is_byte) |=> !accepted_q)
		else $error("frame accepted on a tick");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam logic [fcbc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NO_CUT = 8;
	localparam int CKS_SLOT = 7;
	localparam int LEN_SLOT = 4;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} serial_item_t;

	typedef struct packed {
		logic                          blink_led;
		logic                          ack_led;
		logic                          frame_accepted;
		logic [fcbc_pkg::PERIOD_W-1:0] period_now;
	} lamp_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	fcbc_in_if  in_if();
	fcbc_out_if out_if();
	fcbc_cfg_if cfg_if();

	frame_command_blink_control_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_if),
		.result (out_if),
		.cfg    (cfg_if)
	);

	serial_item_t serial_q[$];
	lamp_state_t  lamp_q[$];
	int           items_open = 0;
	int           pushed_total = 0;
	int           err_count = 0;
	int           quiet_cycles = 0;
	bit           in_took = 1'b0;
	bit           out_took = 1'b0;
	bit           gaps_on = 1'b0;
	bit           stalls_on = 1'b0;
	int unsigned  tx_wait = 0;
	int unsigned  rx_wait = 0;

	// blink controller state
	logic [15:0]          m_inc;
	logic [15:0]          m_dec;
	logic [15:0]          m_init;
	logic [15:0]          m_period;
	logic [15:0]          m_count;
	fcbc_pkg::parse_pos_t m_pos;
	logic [7:0]           m_sum;
	logic [7:0]           m_cmd;
	logic                 m_blink;
	logic                 m_ack;

	function automatic void reset_model();
		m_inc = fcbc_pkg::INC_STEP_RST;
		m_dec = fcbc_pkg::DEC_STEP_RST;
		m_init = fcbc_pkg::INIT_CNT_RST;
		m_period = '0;
		m_count = fcbc_pkg::INIT_CNT_RST;
		m_pos = fcbc_pkg::POS_U;
		m_sum = '0;
		m_cmd = '0;
		m_blink = 1'b0;
		m_ack = 1'b0;
	endfunction

	function automatic void apply_reg(logic [fcbc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
		case (idx)
			fcbc_pkg::REG_INC_STEP: m_inc = v;
			fcbc_pkg::REG_DEC_STEP: m_dec = v;
			fcbc_pkg::REG_INIT_CNT: begin
				m_init = v;
				m_count = v;
			end
			default: ;
		endcase
	endfunction

	function automatic void restart_frame(logic [7:0] b);
		if (b == fcbc_pkg::CH_U) begin
			m_sum = fcbc_pkg::CH_U;
			m_pos = fcbc_pkg::POS_N;
		end else begin
			m_pos = fcbc_pkg::POS_U;
		end
	endfunction

	function automatic void predict_lamps(logic op, logic [7:0] b);
		logic       hit;
		logic [7:0] hdr;
		hit = 1'b0;
		if (op == fcbc_pkg::OP_TICK) begin
			if (m_count != 0)
				m_count = m_count - 16'd1;
		end else begin
			case (m_pos)
				fcbc_pkg::POS_U: restart_frame(b);
				fcbc_pkg::POS_N, fcbc_pkg::POS_E, fcbc_pkg::POS_R: begin
					hdr = (m_pos == fcbc_pkg::POS_N) ? fcbc_pkg::CH_N :
						(m_pos == fcbc_pkg::POS_E) ? fcbc_pkg::CH_E : fcbc_pkg::CH_R;
					if (b == hdr) begin
						m_sum = m_sum ^ b;
						m_pos = fcbc_pkg::parse_pos_t'(m_pos + 3'd1);
					end else begin
						restart_frame(b);
					end
				end
				fcbc_pkg::POS_LEN: begin
					if (b != 8'h00) begin
						m_sum = m_sum ^ b;
						m_pos = fcbc_pkg::POS_COLON;
					end else begin
						restart_frame(b);
					end
				end
				fcbc_pkg::POS_COLON: begin
					if (b == fcbc_pkg::CH_COLON) begin
						m_sum = m_sum ^ b;
						m_pos = fcbc_pkg::POS_CMD;
					end else begin
						restart_frame(b);
					end
				end
				fcbc_pkg::POS_CMD: begin
					m_cmd = b;
					m_sum = m_sum ^ b;
					m_pos = fcbc_pkg::POS_CKS;
				end
				default: begin
					m_pos = fcbc_pkg::POS_U;
					if (b == m_sum) begin
						hit = 1'b1;
						if (m_cmd == fcbc_pkg::CH_PLUS) begin
							m_period = m_period + m_inc;
							m_ack = ~m_ack;
						end else if (m_cmd == fcbc_pkg::CH_MINUS) begin
							m_period = m_period - m_dec;
							m_count = m_period;
						end
					end
				end
			endcase
		end
		if (m_count == 0) begin
			m_count = m_period;
			m_blink = ~m_blink;
		end
		lamp_q.push_back('{m_blink, m_ack, hit, m_period});
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_lamps();
		lamp_state_t want;
		if (lamp_q.size() == 0) begin
			report_mismatch("result with no request waiting");
		end else begin
			want = lamp_q.pop_front();
			items_open--;
			if (out_if.blink_led !== want.blink_led)
				report_mismatch($sformatf("blink_led got %0b expected %0b",
					out_if.blink_led, want.blink_led));
			if (out_if.ack_led !== want.ack_led)
				report_mismatch($sformatf("ack_led got %0b expected %0b",
					out_if.ack_led, want.ack_led));
			if (out_if.frame_accepted !== want.frame_accepted)
				report_mismatch($sformatf("frame_accepted got %0b expected %0b",
					out_if.frame_accepted, want.frame_accepted));
			if (out_if.period_now !== want.period_now)
				report_mismatch($sformatf("period_now got %0d expected %0d",
					out_if.period_now, want.period_now));
		end
	endtask

	// sample at the rising edge
	always @(posedge clk) begin
		bit cfg_took;
		in_took = (in_if.valid === 1'b1) && (in_if.ready === 1'b1);
		out_took = (out_if.valid === 1'b1) && (out_if.ready === 1'b1);
		cfg_took = (cfg_if.valid === 1'b1) && (cfg_if.ready === 1'b1);
		if (out_took)
			check_lamps();
		if (in_took)
			predict_lamps(in_if.operation, in_if.rx_byte);
		if (cfg_took)
			apply_reg(cfg_if.index, cfg_if.data);
		if (in_took || out_took || cfg_took)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		serial_item_t it;
		if (in_if.valid === 1'b1 && !in_took) begin
			// hold until taken
		end else if (tx_wait != 0) begin
			in_if.valid <= 1'b0;
			tx_wait = tx_wait - 1;
		end else if (serial_q.size() != 0) begin
			it = serial_q.pop_front();
			in_if.valid <= 1'b1;
			in_if.operation <= it.operation;
			in_if.rx_byte <= it.rx_byte;
			tx_wait = gaps_on ? $urandom_range(0, 5) : 0;
		end else begin
			in_if.valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		int unsigned w;
		w = rx_wait;
		if (out_took)
			w = stalls_on ? $urandom_range(0, 5) : 0;
		if (w != 0) begin
			out_if.ready <= 1'b0;
			rx_wait = w - 1;
		end else begin
			out_if.ready <= 1'b1;
			rx_wait = 0;
		end
	end

	function automatic logic [7:0] frame_sum(logic [7:0] len, logic [7:0] cmd);
		return fcbc_pkg::CH_U ^ fcbc_pkg::CH_N ^ fcbc_pkg::CH_E ^ fcbc_pkg::CH_R ^ len ^
			fcbc_pkg::CH_COLON ^ cmd;
	endfunction

	function automatic void push_item(logic op, logic [7:0] b);
		serial_q.push_back('{op, b});
		items_open++;
		pushed_total++;
	endfunction

	function automatic void push_frame(logic [7:0] len, logic [7:0] cmd, int cut,
		logic [7:0] bad);
		logic [7:0] f [8];
		int         last;
		f[0] = fcbc_pkg::CH_U;
		f[1] = fcbc_pkg::CH_N;
		f[2] = fcbc_pkg::CH_E;
		f[3] = fcbc_pkg::CH_R;
		f[4] = len;
		f[5] = fcbc_pkg::CH_COLON;
		f[6] = cmd;
		f[7] = frame_sum(len, cmd);
		last = 7;
		if (cut < NO_CUT) begin
			f[cut] = bad;
			last = cut;
		end
		for (int i = 0; i <= last; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_item(fcbc_pkg::OP_TICK, 8'($urandom));
			push_item(fcbc_pkg::OP_BYTE, f[i]);
		end
	endfunction

	task automatic write_reg(logic [fcbc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic program_regs(logic [15:0] inc, logic [15:0] dec, logic [15:0] init);
		write_reg(fcbc_pkg::REG_INC_STEP, inc);
		write_reg(fcbc_pkg::REG_DEC_STEP, dec);
		write_reg(fcbc_pkg::REG_INIT_CNT, init);
	endtask

	task automatic wait_drained();
		while (items_open != 0)
			@(negedge clk);
	endtask

	task automatic run_random(int n);
		int          start;
		int unsigned r;
		int unsigned pick;
		int          cut;
		logic [7:0]  len;
		logic [7:0]  cmd;
		logic [7:0]  bad;
		start = pushed_total;
		while (pushed_total - start < n) begin
			r = $urandom_range(0, 99);
			len = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
			pick = $urandom_range(0, 4);
			cmd = (pick < 2) ? fcbc_pkg::CH_PLUS : (pick < 4) ? fcbc_pkg::CH_MINUS :
				8'($urandom);
			if (r < 45) begin
				push_frame(len, cmd, NO_CUT, 8'h00);
			end else if (r < 62) begin
				case ($urandom_range(0, 5))
					0: cut = 1;
					1: cut = 2;
					2: cut = 3;
					3: cut = LEN_SLOT;
					4: cut = 5;
					default: cut = CKS_SLOT;
				endcase
				if (cut == LEN_SLOT)
					bad = 8'h00;
				else if (cut == CKS_SLOT)
					bad = frame_sum(len, cmd) ^ 8'($urandom_range(1, 255));
				else if ($urandom_range(0, 1) == 0)
					bad = fcbc_pkg::CH_U;
				else
					bad = 8'($urandom);
				push_frame(len, cmd, cut, bad);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8))
					push_item(fcbc_pkg::OP_TICK, 8'($urandom));
			end else begin
				push_item(fcbc_pkg::OP_BYTE, 8'($urandom));
			end
		end
	endtask

	initial begin
		in_if.valid = 1'b0;
		in_if.operation = fcbc_pkg::OP_BYTE;
		in_if.rx_byte = 8'h00;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = fcbc_pkg::REG_INC_STEP;
		cfg_if.data = 16'h0000;
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tick, dropped first byte, header retried as start, then good plus
		push_item(fcbc_pkg::OP_TICK, 8'hFF);
		push_item(fcbc_pkg::OP_BYTE, 8'h00);
		push_item(fcbc_pkg::OP_BYTE, fcbc_pkg::CH_U);
		push_frame(8'hFF, fcbc_pkg::CH_PLUS, NO_CUT, 8'h00);
		// minus with bad checksum, unknown command, zero length
		push_frame(8'h01, fcbc_pkg::CH_MINUS, CKS_SLOT,
			frame_sum(8'h01, fcbc_pkg::CH_MINUS) ^ 8'h01);
		push_frame(8'h80, 8'h00, NO_CUT, 8'h00);
		push_frame(8'h05, fcbc_pkg::CH_PLUS, LEN_SLOT, 8'h00);
		wait_drained();

		for (int ph = 1; ph <= 6; ph++) begin
			case (ph)
				1: begin
					program_regs(16'h0000, 16'h0000, 16'h0000);
					write_reg(REG_SPARE, 16'($urandom));
				end
				2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: program_regs(16'd3, 16'd7, 16'd1);
				4: program_regs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
					16'($urandom_range(0, 40)));
				5: program_regs(16'($urandom), 16'($urandom_range(0, 40)), 16'd20);
				default: program_regs(fcbc_pkg::INC_STEP_RST, fcbc_pkg::DEC_STEP_RST,
					fcbc_pkg::INIT_CNT_RST);
			endcase
			gaps_on = (ph % 4 == 1) || (ph % 4 == 2);
			stalls_on = (ph % 4 == 1) || (ph % 4 == 3);
			run_random(130);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (lamp_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", lamp_q.size()));
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
